// ----- hdl/lsg_pkg.sv -----
// Shared types, register indexes, reset values and the neighbor count
// function for the Game of Life stencil block. No dependencies.
package lsg_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ROW_W      = 16;
  localparam int OUT_COL_W  = 10;
  localparam int GW_W       = 11;
  localparam int MASK_W     = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH   = 2'd0,
    REG_GRID_HEIGHT  = 2'd1,
    REG_BIRTH_MASK   = 2'd2,
    REG_SURVIVE_MASK = 2'd3
  } lsg_reg_idx_t;

  localparam logic [GW_W-1:0]   RST_GRID_WIDTH   = 11'd1024;
  localparam logic [ROW_W-1:0]  RST_GRID_HEIGHT  = 16'd1024;
  localparam logic [MASK_W-1:0] RST_BIRTH_MASK   = 9'b000001000;
  localparam logic [MASK_W-1:0] RST_SURVIVE_MASK = 9'b000001100;

  // One column position of the two stored rows.
  typedef struct packed {
    logic upper;
    logic middle;
  } lsg_lines_t;

  // One result beat.
  typedef struct packed {
    logic                 next_cell;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 frame_done;
  } lsg_result_t;

  // Live cells of the 3x3 window, the center cell (bit 4) left out.
  function automatic logic [3:0] count_neighbors(input logic [8:0] win);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 0; b < 9; b++) begin
      if (b != 4) n = n + {3'd0, win[b]};
    end
    return n;
  endfunction

endpackage

// ----- hdl/lsg_line_store.sv -----
// Two one-bit row stores with registered read, written and read once a cycle.
// Holds its own clearing pass after reset. Depends on lsg_pkg.
module lsg_line_store import lsg_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  lsg_lines_t               wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output lsg_lines_t               rd_data,
  output logic                     clearing
);

  localparam int AW = $clog2(DEPTH);

  logic          upper_mem  [DEPTH];
  logic          middle_mem [DEPTH];
  lsg_lines_t    rd_data_r;
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) clr_active_r <= 1'b0;
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      upper_mem[clr_addr_r]  <= 1'b0;
      middle_mem[clr_addr_r] <= 1'b0;
    end else if (wr_en) begin
      upper_mem[wr_addr]  <= wr_data.upper;
      middle_mem[wr_addr] <= wr_data.middle;
    end
    rd_data_r.upper  <= upper_mem[rd_addr];
    rd_data_r.middle <= middle_mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_active_r;

endmodule

// ----- hdl/life_stencil_generation_top.sv -----
// Top level of the Game of Life stencil block: configuration registers,
// raster counters, 3x3 window, rule lookup and output skid stage.
// Depends on lsg_pkg and lsg_line_store.
//
//   Channel  Direction  Handshake               Beat carries
//   in_      input      in_valid / in_stall     in_cell_in
//   out_     output     out_valid / out_stall   out_next_cell, out_row, out_col,
//                                               out_frame_done
//   cfg_     input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One cell is accepted per clock while in_stall is low; the result of the cell that
// completes its window is registered in the output register, or in the skid entry.
// After reset the row stores are cleared, one entry a cycle, through all MAX_WIDTH
// entries, and the read port is then primed; no cell is taken meanwhile.
// A configuration write stalls the input in the cycle after it, while the row store
// read is redone at the new geometry.
// A two-entry output stage (register plus skid) lets a cell be taken while a
// result waits; of the output stage, only a full skid entry raises in_stall.
module life_stencil_generation_top import lsg_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Cell stream.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cell_in,
  // Result stream.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_next_cell,
  output logic [ROW_W-1:0]      out_row,
  output logic [OUT_COL_W-1:0]  out_col,
  output logic                  out_frame_done,
  // Register writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);

  // Configuration registers.
  logic [GW_W-1:0]   grid_width_r;
  logic [ROW_W-1:0]  grid_height_r;
  logic [MASK_W-1:0] birth_mask_r;
  logic [MASK_W-1:0] survive_mask_r;

  // Raster position, window and handshake state.
  logic [AW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [8:0]       win_r, win_nxt;
  logic             fresh_r;
  lsg_result_t      out_r, skid_r, res;
  logic             out_valid_r, skid_valid_r;

  logic             cfg_fire, acc, res_valid, out_take, clearing;
  logic [31:0]      gw32;
  logic [AW-1:0]    wlast, col_cur, col_m1, rd_addr;
  logic [ROW_W-1:0] hlast, row_cur;
  logic [3:0]       nbr;
  logic [MASK_W-1:0] rule_mask;
  lsg_lines_t       lines_rd, lines_wr;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  // The input waits while the stores are cleared, in the cycle after a register
  // write or the end of clearing, and while the skid entry is full.
  assign in_stall = clearing | fresh_r | skid_valid_r;
  assign acc      = in_valid & ~in_stall;

  // Effective geometry: width clamped to 3..MAX_WIDTH, height at least 3.
  // Both are kept as the index of the last column and row.
  assign gw32 = 32'(grid_width_r);
  always_comb begin
    if (gw32 < 32'd3) begin
      wlast = AW'(2);
    end else if (gw32 > 32'(MAX_WIDTH)) begin
      wlast = AW'(MAX_WIDTH - 1);
    end else begin
      wlast = AW'(gw32 - 32'd1);
    end
    if (grid_height_r < 16'd3) begin
      hlast = 16'd2;
    end else begin
      hlast = grid_height_r - 16'd1;
    end
  end

  // A counter left beyond the geometry by a register write is read as the
  // last column or row.
  assign col_cur = (col_r > wlast) ? wlast : col_r;
  assign row_cur = (row_r > hlast) ? hlast : row_r;
  assign col_m1  = col_cur - AW'(1);

  always_comb begin
    if (col_cur == wlast) begin
      col_nxt = '0;
      row_nxt = (row_cur == hlast) ? '0 : row_cur + 16'd1;
    end else begin
      col_nxt = col_cur + AW'(1);
      row_nxt = row_cur;
    end
  end

  // The read port runs one cell ahead: on an accepted beat it fetches the
  // next column, otherwise it keeps refreshing the current one. The next
  // column never equals the one written in the same cycle.
  assign rd_addr = acc ? col_nxt : col_cur;

  assign lines_wr.upper  = lines_rd.middle;
  assign lines_wr.middle = in_cell_in;

  lsg_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (acc),
    .wr_addr  (col_cur),
    .wr_data  (lines_wr),
    .rd_addr  (rd_addr),
    .rd_data  (lines_rd),
    .clearing (clearing)
  );

  // The newest column enters at the top of the window: bit 6 is the upper
  // row, bit 7 the middle row, bit 8 the incoming cell.
  assign win_nxt   = {in_cell_in, lines_rd.middle, lines_rd.upper, win_r[8:3]};
  assign nbr       = count_neighbors(win_nxt);
  assign rule_mask = win_nxt[4] ? survive_mask_r : birth_mask_r;

  assign res_valid      = acc && (row_cur >= 16'd2) && (col_cur >= AW'(2));
  assign res.next_cell  = rule_mask[nbr];
  assign res.row        = row_cur - 16'd1;
  assign res.col        = OUT_COL_W'(col_m1);
  assign res.frame_done = (row_cur == hlast) && (col_cur == wlast);

  assign out_take = out_valid_r & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r   <= RST_GRID_WIDTH;
      grid_height_r  <= RST_GRID_HEIGHT;
      birth_mask_r   <= RST_BIRTH_MASK;
      survive_mask_r <= RST_SURVIVE_MASK;
      col_r          <= '0;
      row_r          <= '0;
      win_r          <= '0;
      fresh_r        <= 1'b1;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (lsg_reg_idx_t'(cfg_index))
          REG_GRID_WIDTH:   grid_width_r   <= cfg_data[GW_W-1:0];
          REG_GRID_HEIGHT:  grid_height_r  <= cfg_data[ROW_W-1:0];
          REG_BIRTH_MASK:   birth_mask_r   <= cfg_data[MASK_W-1:0];
          REG_SURVIVE_MASK: survive_mask_r <= cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
      fresh_r <= clearing | cfg_fire;

      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        win_r <= win_nxt;
      end

      if (!out_valid_r || out_take) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_r       <= res;
          out_valid_r <= res_valid;
        end
      end else if (res_valid) begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_next_cell  = out_r.next_cell;
  assign out_row        = out_r.row;
  assign out_col        = out_r.col;
  assign out_frame_done = out_r.frame_done;

`ifndef SYNTHESIS
  // The skid entry is only ever filled behind a waiting output beat.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry occupied with empty output register");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid entry filled while output was free");

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !clearing)
    else $error("cell accepted during row store clearing");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !cfg_fire) |=> (col_r <= wlast))
    else $error("column counter beyond last column");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for life_stencil_generation_top: streams raster frames of cells,
// predicts each interior cell's next generation and checks every result beat.
// Depends on lsg_pkg and the block's RTL; needs nothing else.
module tb_top;
  import lsg_pkg::*;

  localparam int MAX_W        = 1024;
  localparam int HOLD_CYCLES  = 200;   // long receiver hold-off, in cycles
  localparam int STALL_LIMIT  = 4000;  // cycles with no beat anywhere before giving up
  localparam int ITEM_TARGET  = 1150;  // cells in the whole run, directed part included
  localparam int WIDE_AFTER   = 80;    // the full-width row starts once this many are in

  // Directed rows either carry a register write or one cell. A cell row says how its
  // result is judged: by the predictor, as "no result at all", or by a typed-in beat.
  typedef enum logic {ROW_CELL, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} check_t;

  typedef struct packed {
    row_kind_t             kind;
    lsg_reg_idx_t          idx;
    logic [CFG_DATA_W-1:0] value;
    logic                  alive;
    check_t                chk;
    lsg_result_t           want;
  } script_row_t;

  localparam lsg_result_t NO_RESULT = '0;
  // All nine cells alive: the center has eight neighbors and the Conway rule kills it.
  localparam lsg_result_t CROWDED   = '{1'b0, 16'd1, 10'd1, 1'b1};
  // All nine cells dead with a birth mask of all ones: zero neighbors still gives birth.
  localparam lsg_result_t BORN_ALONE = '{1'b1, 16'd1, 10'd1, 1'b1};

  // The directed part. Two cells go in at the reset geometry (1024 x 1024), where row 0
  // never reports. The width is then cut to 0 (taken as 3) with the column counter
  // already on the new last column, and the height to 1 (taken as 3). That finishes a
  // 3 x 3 frame of live cells. A second, all-dead frame runs with the masks at their
  // opposite extremes.
  localparam script_row_t DIRECTED [22] = '{
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b1, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b1, CHK_NONE,  NO_RESULT},
    '{ROW_WRITE, REG_GRID_WIDTH,   16'd0,   1'b0, CHK_NONE,  NO_RESULT},
    '{ROW_WRITE, REG_GRID_HEIGHT,  16'd1,   1'b0, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b1, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b1, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b1, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b1, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b1, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b1, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b1, CHK_GIVEN, CROWDED},
    '{ROW_WRITE, REG_BIRTH_MASK,   16'd511, 1'b0, CHK_NONE,  NO_RESULT},
    '{ROW_WRITE, REG_SURVIVE_MASK, 16'd0,   1'b0, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b0, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b0, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b0, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b0, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b0, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b0, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b0, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b0, CHK_NONE,  NO_RESULT},
    '{ROW_CELL,  REG_GRID_WIDTH,   16'd0,   1'b0, CHK_GIVEN, BORN_ALONE}
  };

  // Every input of the block starts at a known value.
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic                  in_cell_in = 1'b0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic                  out_next_cell;
  logic [ROW_W-1:0]      out_row;
  logic [OUT_COL_W-1:0]  out_col;
  logic                  out_frame_done;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  life_stencil_generation_top #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cell_in    (in_cell_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_next_cell (out_next_cell),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_frame_done(out_frame_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 2 ns clock: one delay high, one low.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: the register copies, the two stored rows, the 3x3 window and the
  // raster position of the next cell.
  logic [GW_W-1:0]   reg_width;
  logic [ROW_W-1:0]  reg_height;
  logic [MASK_W-1:0] rule_birth;
  logic [MASK_W-1:0] rule_survive;
  logic              upper_line [MAX_W];
  logic              middle_line [MAX_W];
  logic [8:0]        stencil;
  int unsigned       col_pos;
  int unsigned       row_pos;

  lsg_result_t expected_cells[$];  // next-generation beats still to arrive, oldest first
  int          errors;
  int unsigned cells_sent;
  bit          sender_calm;        // sender offers a cell every cycle while set
  bit          hold_request;       // asks the receiver for one long hold-off

  // Geometry actually used: the width is held to 3..MAX_W and the height to at least 3.
  function automatic int unsigned used_width();
    int unsigned w;
    w = reg_width;
    if (w < 3) w = 3;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned used_height();
    int unsigned h;
    h = reg_height;
    if (h < 3) h = 3;
    return h;
  endfunction

  // Advances the predicted raster by one cell. The window keeps three columns; each
  // column holds the upper, middle and new row in its bits 0, 1 and 2, with the newest
  // column on top. Once both counters are past the first two, the window is complete
  // for the cell one row up and one column left.
  function automatic void step_generation(input logic alive, output bit produced,
                                          output lsg_result_t res);
    int unsigned w, h, c, r, n;
    logic        up, mid;
    w = used_width();
    h = used_height();
    // A geometry change in the middle of a frame can leave the counters past the end.
    c = (col_pos > w - 1) ? w - 1 : col_pos;
    r = (row_pos > h - 1) ? h - 1 : row_pos;
    up  = upper_line[c];
    mid = middle_line[c];
    stencil = {alive, mid, up, stencil[8:3]};
    produced = (r >= 2) && (c >= 2);
    n = $countones(stencil) - stencil[4];
    res.next_cell  = stencil[4] ? rule_survive[n] : rule_birth[n];
    res.row        = ROW_W'(r - 1);
    res.col        = OUT_COL_W'(c - 1);
    res.frame_done = (r == h - 1) && (c == w - 1);
    upper_line[c]  = mid;
    middle_line[c] = alive;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  // Idle stretch for either side: mostly none, often a few cycles, now and then long.
  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    errors++;
  endtask

  // Offers one cell beat and waits for it to be taken. Valid stays high afterwards so
  // that back-to-back cells need no second assignment in the same step. The stall seen
  // right after the edge is the value the block had at that edge.
  task automatic send_cell(input logic alive, input check_t chk, input lsg_result_t given);
    int          gap;
    bit          produced;
    lsg_result_t res;
    gap = sender_calm ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cell_in <= alive;
    do @(posedge clk); while (in_stall !== 1'b0);
    step_generation(alive, produced, res);
    if (chk == CHK_GIVEN) expected_cells.push_back(given);
    else if (chk == CHK_MODEL && produced) expected_cells.push_back(res);
    cells_sent++;
  endtask

  // Register writes happen only with the block idle: input held off, every expected
  // beat delivered, and a few cycles more for cells that report nothing (a border cell
  // is still in the pipeline when the last result has left).
  task automatic write_register(input lsg_reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:   reg_width    = value[GW_W-1:0];
      REG_GRID_HEIGHT:  reg_height   = value[ROW_W-1:0];
      REG_BIRTH_MASK:   rule_birth   = value[MASK_W-1:0];
      REG_SURVIVE_MASK: rule_survive = value[MASK_W-1:0];
      default: ;
    endcase
  endtask

  // Result side. Each accepted beat is matched against the oldest expectation, field by
  // field; a beat with nothing waiting is an error of its own.
  always @(posedge clk) begin
    lsg_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_cells.size() == 0) begin
        report_mismatch($sformatf("result beat row %0d col %0d with nothing expected",
                                  out_row, out_col));
      end else begin
        want = expected_cells.pop_front();
        if (out_next_cell !== want.next_cell)
          report_mismatch($sformatf("next_cell %b, want %b (row %0d col %0d)",
                                    out_next_cell, want.next_cell, want.row, want.col));
        if (out_row !== want.row)
          report_mismatch($sformatf("out_row %0d, want %0d", out_row, want.row));
        if (out_col !== want.col)
          report_mismatch($sformatf("out_col %0d, want %0d", out_col, want.col));
        if (out_frame_done !== want.frame_done)
          report_mismatch($sformatf("frame_done %b, want %b (row %0d col %0d)",
                                    out_frame_done, want.frame_done, want.row, want.col));
      end
    end
  end

  // Receiver. Random stall stretches alternate with bursts of free flow. When asked,
  // it holds off for a long stretch so that the output stage fills and the block has
  // to stall its input while the sender keeps offering cells.
  initial begin : receiver
    int gap;
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        gap = idle_length();
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // Watchdog. The longest quiet stretch in a good run is the row store clear after
  // reset; the limit lies well above it.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_top failed");
    $finish;
  end

  // Stimulus.
  initial begin : stimulus
    lsg_reg_idx_t          idx;
    logic [CFG_DATA_W-1:0] value;
    logic [MASK_W-1:0]     mask;
    int unsigned           w, h, count, density, first, roll;
    bit                    wide_done;

    // Predictor at its reset state.
    reg_width    = RST_GRID_WIDTH;
    reg_height   = RST_GRID_HEIGHT;
    rule_birth   = RST_BIRTH_MASK;
    rule_survive = RST_SURVIVE_MASK;
    for (int i = 0; i < MAX_W; i++) begin
      upper_line[i]  = 1'b0;
      middle_line[i] = 1'b0;
    end
    stencil      = '0;
    col_pos      = 0;
    row_pos      = 0;
    errors       = 0;
    cells_sent   = 0;
    sender_calm  = 1'b0;
    hold_request = 1'b0;
    wide_done    = 1'b0;

    // Reset is applied once. The block then clears its row stores before it takes
    // the first cell; the handshakes absorb that.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].kind == ROW_WRITE)
        write_register(DIRECTED[i].idx, DIRECTED[i].value);
      else
        send_cell(DIRECTED[i].alive, DIRECTED[i].chk, DIRECTED[i].want);
    end

    // Random part: phases of small geometries. Each phase rewrites a random subset of
    // the registers in random order, with junk above the used bits of the width and mask
    // registers, and then streams a random stretch of cells. Some stretches stop
    // mid-frame, so the next phase changes the geometry under running counters.
    while (cells_sent < ITEM_TARGET) begin
      if (!wide_done && cells_sent >= WIDE_AFTER) begin
        // One full-width row. A 3 x 3 geometry brings the raster to the start of row 2;
        // then the width goes to all ones (taken as MAX_W) and the height to its maximum,
        // and one whole row is streamed, reporting up to the last possible column.
        wide_done = 1'b1;
        write_register(REG_GRID_WIDTH, 16'd3);
        write_register(REG_GRID_HEIGHT, 16'd3);
        while (!(row_pos == 2 && col_pos == 0))
          send_cell(1'($urandom_range(0, 1)), CHK_MODEL, NO_RESULT);
        write_register(REG_GRID_WIDTH, 16'hFFFF);
        write_register(REG_GRID_HEIGHT, 16'hFFFF);
        sender_calm  = 1'b1;
        hold_request = 1'b1;
        repeat (MAX_W) send_cell(1'($urandom_range(0, 1)), CHK_MODEL, NO_RESULT);
        continue;
      end

      first = $urandom_range(0, 3);
      for (int k = 0; k < 4; k++) begin
        if (k == 0 || $urandom_range(0, 4) != 0) begin
          idx  = lsg_reg_idx_t'((first + k) % 4);
          roll = $urandom_range(0, 9);
          case (idx)
            REG_GRID_WIDTH: begin
              // Mostly small grids, sometimes below the minimum.
              if (roll < 8) value = {5'($urandom), 11'($urandom_range(3, 12))};
              else          value = {5'($urandom), 11'($urandom_range(0, 2))};
            end
            REG_GRID_HEIGHT: begin
              if (roll < 7)       value = 16'($urandom_range(1, 8));
              else if (roll == 7) value = 16'd0;
              else if (roll == 8) value = 16'($urandom_range(3, 8));
              else                value = 16'hFFFF;
            end
            default: begin
              if (roll < 5)
                mask = (idx == REG_BIRTH_MASK) ? RST_BIRTH_MASK : RST_SURVIVE_MASK;
              else if (roll < 8) mask = 9'($urandom);
              else if (roll == 8) mask = '0;
              else mask = '1;
              value = {7'($urandom), mask};
            end
          endcase
          write_register(idx, value);
        end
      end

      w = used_width();
      h = used_height();
      if (h > 8) h = 8;
      if ($urandom_range(0, 3) == 0) count = $urandom_range(1, 3 * w);
      else                           count = $urandom_range(w * h, 2 * w * h);
      density     = $urandom_range(5, 80);
      sender_calm = ($urandom_range(0, 3) == 0);
      repeat (count) send_cell($urandom_range(0, 99) < density, CHK_MODEL, NO_RESULT);
    end

    // Drain: every expected beat, then a few cycles in case anything extra follows.
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/lsg_pkg.sv
hdl/lsg_line_store.sv
hdl/life_stencil_generation_top.sv
test/tb_top.sv
